### rtl/shs_pkg.sv
`timescale 1ns / 1ps

package shs_pkg;

   // Byte source for a block write
   localparam logic [1:0] SEL_MSG  = 2'd0;
   localparam logic [1:0] SEL_MARK = 2'd1;
   localparam logic [1:0] SEL_ZERO = 2'd2;
   localparam logic [1:0] SEL_LEN  = 2'd3;

   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS       = 6'd56;
   localparam logic [5:0] LAST_POS      = 6'd63;
   localparam logic [5:0] LAST_ROUND    = 6'd63;
   localparam logic [2:0] LAST_WORD     = 3'd7;

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Controller to datapath
   typedef struct packed {
      logic       wr_en;      // write one byte into the block
      logic [1:0] byte_sel;   // source of that byte
      logic       count_en;   // byte belongs to the message: bump bit count
      logic       load_vars;  // working vars <= chaining words
      logic       round_en;   // run one compression round
      logic [5:0] round_idx;
      logic       chain_add;  // chaining words += working vars
      logic       restart;    // back to initial values
      logic [2:0] word_idx;   // digest word on the output
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [5:0] pos;        // next byte position in the block
   } status_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

### rtl/shs_ctrl.sv
`timescale 1ns / 1ps

module shs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_byte_present,
   input  logic               req_end_of_message,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  shs_pkg::status_type status,
   output shs_pkg::cmd_type   cmd
);
   import shs_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ROUND  = 3'd1;
   localparam logic [2:0] ST_UPDATE = 3'd2;
   localparam logic [2:0] ST_PAD    = 3'd3;
   localparam logic [2:0] ST_OUT    = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [2:0] ret_ff, ret_in;
   logic [5:0] round_ff, round_in;
   logic [2:0] word_ff, word_in;
   logic       mark_done_ff, mark_done_in;
   logic       len_block_ff, len_block_in;
   logic       accept;
   logic [1:0] pad_sel;

   assign accept = req_valid && req_ready;

   always_comb begin
      if (!mark_done_ff) begin
         pad_sel = SEL_MARK;
      end else if (status.pos >= LEN_POS && len_block_ff) begin
         pad_sel = SEL_LEN;
      end else begin
         pad_sel = SEL_ZERO;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      round_in     = round_ff;
      word_in      = word_ff;
      mark_done_in = mark_done_ff;
      len_block_in = len_block_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      cmd          = '0;
      cmd.byte_sel = SEL_MSG;
      cmd.round_idx = round_ff;
      cmd.word_idx = word_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.wr_en    = accept && req_byte_present;
            cmd.count_en = accept && req_byte_present;
            if (accept) begin
               mark_done_in = 1'b0;
               if (req_byte_present && status.pos == LAST_POS) begin
                  cmd.load_vars = 1'b1;
                  round_in      = '0;
                  state_in      = ST_ROUND;
                  ret_in        = req_end_of_message ? ST_PAD : ST_IDLE;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.wr_en    = 1'b1;
            cmd.byte_sel = pad_sel;
            mark_done_in = 1'b1;
            if (!mark_done_ff) begin
               len_block_in = status.pos < LEN_POS;
            end
            if (status.pos == LAST_POS) begin
               cmd.load_vars = 1'b1;
               round_in      = '0;
               state_in      = ST_ROUND;
               if (pad_sel == SEL_LEN) begin
                  ret_in = ST_OUT;
               end else begin
                  // extra block: the length goes into the next one
                  ret_in       = ST_PAD;
                  len_block_in = 1'b1;
               end
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.chain_add = 1'b1;
            state_in      = ret_ff;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               word_in = word_ff + 3'd1;
               if (word_ff == LAST_WORD) begin
                  cmd.restart = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         round_ff     <= '0;
         word_ff      <= '0;
         mark_done_ff <= 1'b0;
         len_block_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         round_ff     <= round_in;
         word_ff      <= word_in;
         mark_done_ff <= mark_done_in;
         len_block_ff <= len_block_in;
      end
   end

endmodule

### rtl/shs_datapath.sv
`timescale 1ns / 1ps

module shs_datapath (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         req_message_byte,
   input  shs_pkg::cmd_type   cmd,
   output shs_pkg::status_type status,
   output logic [31:0]        rsp_digest_word
);
   import shs_pkg::*;

   logic [31:0] chain_ff [8];
   logic [31:0] vars_ff [8];
   logic [31:0] w_ff [16];       // schedule shift line, w_ff[0] is oldest
   logic [23:0] acc_ff;          // first three bytes of the word being packed
   logic [63:0] bit_count_ff;
   logic [5:0]  pos_ff;

   logic [7:0]  wr_byte;
   logic [2:0]  len_idx;
   logic [31:0] packed_word;
   logic [31:0] new_w;
   logic [31:0] t1, t2;

   assign status.pos = pos_ff;
   assign rsp_digest_word = chain_ff[cmd.word_idx];

   // length bytes go out most significant first
   assign len_idx = ~pos_ff[2:0];

   always_comb begin
      case (cmd.byte_sel)
         SEL_MSG:  wr_byte = req_message_byte;
         SEL_MARK: wr_byte = PAD_MARK_BYTE;
         SEL_LEN:  wr_byte = bit_count_ff[{len_idx, 3'b000} +: 8];
         default:  wr_byte = 8'h00;
      endcase
   end

   assign packed_word = {acc_ff, wr_byte};

   assign new_w = (rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10))
                + w_ff[9]
                + (rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3))
                + w_ff[0];

   assign t1 = vars_ff[7]
             + (rotr(vars_ff[4], 6) ^ rotr(vars_ff[4], 11) ^ rotr(vars_ff[4], 25))
             + ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]))
             + ROUND_K[cmd.round_idx] + w_ff[0];
   assign t2 = (rotr(vars_ff[0], 2) ^ rotr(vars_ff[0], 13) ^ rotr(vars_ff[0], 22))
             + ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
                ^ (vars_ff[1] & vars_ff[2]));

   // chaining words, bit count and byte position
   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= INIT_H[i];
         end
         bit_count_ff <= '0;
         pos_ff       <= '0;
      end else begin
         if (cmd.chain_add) begin
            for (int i = 0; i < 8; i++) begin
               chain_ff[i] <= chain_ff[i] + vars_ff[i];
            end
         end
         if (cmd.count_en) begin
            bit_count_ff <= bit_count_ff + 64'd8;
         end
         if (cmd.wr_en) begin
            pos_ff <= pos_ff + 6'd1;
         end
      end
   end

   // block packing, schedule and working vars
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         acc_ff <= packed_word[23:0];
         if (pos_ff[1:0] == 2'b11) begin
            for (int i = 0; i < 15; i++) begin
               w_ff[i] <= w_ff[i + 1];
            end
            w_ff[15] <= packed_word;
         end
      end else if (cmd.round_en) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[15] <= new_w;
      end
      if (cmd.load_vars) begin
         for (int i = 0; i < 8; i++) begin
            vars_ff[i] <= chain_ff[i];
         end
      end else if (cmd.round_en) begin
         vars_ff[0] <= t1 + t2;
         vars_ff[1] <= vars_ff[0];
         vars_ff[2] <= vars_ff[1];
         vars_ff[3] <= vars_ff[2];
         vars_ff[4] <= vars_ff[3] + t1;
         vars_ff[5] <= vars_ff[4];
         vars_ff[6] <= vars_ff[5];
         vars_ff[7] <= vars_ff[6];
      end
   end

endmodule

### rtl/sha256_stream_hasher_unit.sv
`timescale 1ns / 1ps
// Message bytes are taken one per cycle while req_ready is high; the 64th byte of a
// block starts the 64 rounds of the single round unit, then the chaining update.
// End of message: pad bytes are written one per cycle up to the block end, then one
// compression (two when the length spills into an extra block), then eight
// digest words at one per cycle while rsp_ready is high. One transaction at a time.
// Reset (synchronous, active high) loads the initial hash values and clears the count.

module sha256_stream_hasher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_message_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import shs_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Controller: idle / padding / rounds / chaining update / digest output.
   // Padding is fed through the same byte path as message bytes, one per cycle.
   shs_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .status             (status),
      .cmd                (cmd)
   );

   // Datapath: bytes are packed big-endian straight into the 16-word schedule
   // shift line, so no separate block buffer is kept.
   shs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_message_byte (req_message_byte),
      .cmd              (cmd),
      .status           (status),
      .rsp_digest_word  (rsp_digest_word)
   );

   assign rsp_word_index = cmd.word_idx;
   assign rsp_last_word  = (cmd.word_idx == LAST_WORD);

endmodule
